// ===== rtl/core/dtog_pkg.sv =====
// ----------------------------------------------------------------------------
// dtog_pkg
// Shared types and constants of the disparity to occupancy grid unit.
// ----------------------------------------------------------------------------
package dtog_pkg;

  // divider operand widths: column numerator is a signed 38-bit value,
  // column denominator 4*q*f needs 25 bits
  localparam int NUM_W = 38;
  localparam int DEN_W = 25;
  localparam int CNT_W = 6;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_COLUMN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_PIXELS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_BASELINE_CM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_DEPTH_CM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_WIDTH_CM    = 3'd4;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ_CLEAR = 1'b1;

  localparam logic [10:0] MIN_DISP_Q4   = 11'd16;
  localparam logic [10:0] DISP_CLAMP_Q4 = 11'd1024;
  localparam logic [8:0]  FAR_LIMIT_CM  = 9'd500;
  localparam logic [8:0]  COUNT_MAX     = 9'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ROW_GO,
    ST_ROW_WAIT,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/dtog_div.sv =====
// ----------------------------------------------------------------------------
// dtog_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtog_div
  import dtog_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, acc[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      acc <= num;
    end else if (busy) begin
      // quotient bits shift in at the bottom as numerator bits leave the top
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[DEN_W-1:0];
      end
      acc <= {acc[NUM_W-2:0], fits};
    end
  end

  assign quo = acc;

endmodule

// ===== rtl/core/dtog_mem.sv =====
// ----------------------------------------------------------------------------
// dtog_mem
// Grid count memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module dtog_mem
  import dtog_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          busy
);

  logic [7:0]    mem [2**AW];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {AW{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/disparity_to_occupancy_grid_unit.sv =====
// ----------------------------------------------------------------------------
// disparity_to_occupancy_grid_unit
// Maps disparity pixels into a top-down grid of 2 cm cells and counts hits.
// ----------------------------------------------------------------------------
// accumulate word: two passes of the shared bit-serial divider (row, then column)
//   between the multiply states and the read and write of the grid cell
// read and clear words and pixels rejected before the divider skip both passes
// one word in flight; the next is taken the cycle after the result register loads
// reset: control and configuration registers return to defaults, then a clearing
//   pass zeroes the grid memory while in_stall is held high
module disparity_to_occupancy_grid_unit
  import dtog_pkg::*;
#(
  parameter int GRID_ROWS   = 256,
  parameter int GRID_COLS   = 256,
  parameter int IMAGE_WIDTH = 640
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [9:0]           pixel_column,
  input  logic [10:0]          disparity_q4,
  input  logic [7:0]           read_row,
  input  logic [7:0]           read_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 cell_hit,
  output logic [7:0]           cell_row,
  output logic [7:0]           cell_col,
  output logic [7:0]           cell_count
);

  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int AW = RW + CW;

  state_t state;
  state_t state_next;

  logic [9:0]  principal_column;
  logic [11:0] focal_pixels;
  logic [19:0] focal_baseline_cm;
  logic [9:0]  range_depth_cm;
  logic [9:0]  range_width_cm;

  logic        op;
  logic [9:0]  u;
  logic [10:0] q;
  logic [7:0]  rr;
  logic [7:0]  rc;

  logic signed [31:0] p_ub;
  logic [22:0]        qf;
  logic signed [24:0] num_row;
  logic [32:0]        wqf;
  logic               neg;
  logic [NUM_W-1:0]   row_q;

  logic        res_hit;
  logic [7:0]  res_row;
  logic [7:0]  res_col;
  logic [7:0]  res_count;

  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;

  logic          mem_rd;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          mem_busy;

  logic                    accept;
  logic                    out_free;
  logic signed [10:0]      diff_u;
  logic signed [NUM_W-1:0] num_col;
  logic signed [NUM_W-1:0] num_row_x;
  logic                    reject_pre;
  logic                    reject_row;
  logic                    reject_col;
  logic                    read_outside;
  logic [10:0]             qc;
  logic [2:0]              weight;
  logic [8:0]              sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || mem_busy;
  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      principal_column  <= 10'd320;
      focal_pixels      <= 12'd500;
      focal_baseline_cm <= 20'd6000;
      range_depth_cm    <= 10'd500;
      range_width_cm    <= 10'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRINCIPAL_COLUMN:  principal_column  <= cfg_data[9:0];
        CFG_FOCAL_PIXELS:      focal_pixels      <= cfg_data[11:0];
        CFG_FOCAL_BASELINE_CM: focal_baseline_cm <= cfg_data;
        CFG_RANGE_DEPTH_CM:    range_depth_cm    <= cfg_data[9:0];
        CFG_RANGE_WIDTH_CM:    range_width_cm    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // combinational checks
  assign diff_u = $signed({1'b0, u}) - $signed({1'b0, principal_column});

  assign reject_pre = (q <= MIN_DISP_Q4) || ({1'b0, u} >= 11'(IMAGE_WIDTH)) ||
                      (focal_pixels == '0) ||
                      ({focal_baseline_cm, 4'b0} >= 24'(FAR_LIMIT_CM) * 24'(q));

  assign read_outside = ({3'b0, rr} >= 11'(GRID_ROWS)) ||
                        ({3'b0, rc} >= 11'(GRID_COLS));

  assign num_row_x = NUM_W'(num_row);
  // column numerator: 32*(u-u0)*fb + W*q*f
  assign num_col = $signed({{(NUM_W-37){p_ub[31]}}, p_ub, 5'b0}) +
                   $signed({{(NUM_W-33){1'b0}}, wqf});

  // truncation toward zero: a negative value only survives as zero
  assign reject_row = (neg && div_quo != '0) ||
                      (div_quo >= NUM_W'(range_depth_cm[9:1])) ||
                      (div_quo >= NUM_W'(GRID_ROWS));
  assign reject_col = (neg && div_quo != '0) ||
                      (div_quo >= NUM_W'(range_width_cm[9:1])) ||
                      (div_quo >= NUM_W'(GRID_COLS));

  assign qc     = (q > DISP_CLAMP_Q4) ? DISP_CLAMP_Q4 : q;
  assign weight = 3'((DISP_CLAMP_Q4 - qc) >> 8) + 3'd1;
  assign sum    = {1'b0, mem_rdata} + {6'b0, weight};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    mem_rd = 1'b0;
    mem_we = 1'b0;
    mem_wdata = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (op == OP_READ_CLEAR) begin
          state_next = read_outside ? ST_DONE : ST_RD;
        end else begin
          state_next = reject_pre ? ST_DONE : ST_MUL2;
        end
      end
      ST_MUL2: state_next = ST_ROW_GO;
      ST_ROW_GO: begin
        div_start = 1'b1;
        div_num = num_row_x[NUM_W-1] ? NUM_W'(-num_row_x) : NUM_W'(num_row_x);
        div_den = DEN_W'({q, 1'b0});
        state_next = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (div_done) begin
          state_next = reject_row ? ST_DONE : ST_COL_GO;
        end
      end
      ST_COL_GO: begin
        div_start = 1'b1;
        div_num = num_col[NUM_W-1] ? NUM_W'(-num_col) : NUM_W'(num_col);
        div_den = {qf, 2'b0};
        state_next = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        if (div_done) begin
          state_next = reject_col ? ST_DONE : ST_RD;
        end
      end
      ST_RD: begin
        mem_rd = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        mem_we = 1'b1;
        if (op == OP_ACCUMULATE) begin
          mem_wdata = (sum >= COUNT_MAX) ? COUNT_MAX[7:0] : sum[7:0];
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign mem_addr = {RW'(res_row), CW'(res_col)};

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op <= operation;
          u  <= pixel_column;
          q  <= disparity_q4;
          rr <= read_row;
          rc <= read_col;
        end
        res_hit   <= 1'b0;
        res_row   <= '0;
        res_col   <= '0;
        res_count <= '0;
      end
      ST_MUL1: begin
        p_ub    <= diff_u * $signed({1'b0, focal_baseline_cm});
        qf      <= {12'b0, q} * {11'b0, focal_pixels};
        num_row <= $signed(25'({range_depth_cm, 11'b0} >> 11) * 25'(q)) -
                   $signed({1'b0, focal_baseline_cm, 4'b0});
        if (op == OP_READ_CLEAR && !read_outside) begin
          res_row <= rr;
          res_col <= rc;
        end
      end
      ST_MUL2: begin
        wqf <= {23'b0, range_width_cm} * {10'b0, qf};
      end
      ST_ROW_GO: neg <= num_row[24];
      ST_ROW_WAIT: row_q <= div_quo;
      ST_COL_GO: neg <= num_col[NUM_W-1];
      ST_COL_WAIT: begin
        if (div_done && !reject_col) begin
          res_row <= row_q[7:0];
          res_col <= div_quo[7:0];
        end
      end
      ST_WR: begin
        res_hit   <= 1'b1;
        res_count <= (op == OP_ACCUMULATE) ? mem_wdata : mem_rdata;
      end
      default: ;
    endcase
  end

  // result register, parts the output side from the working item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      cell_hit   <= res_hit;
      cell_row   <= res_row;
      cell_col   <= res_col;
      cell_count <= res_count;
    end
  end

  dtog_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  dtog_mem #(
    .AW (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (mem_wdata),
    .busy    (mem_busy)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("word accepted while previous word still in work");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_hit |-> cell_row == '0 && cell_col == '0 && cell_count == '0)
    else $error("miss result carries non-zero fields");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> in_stall)
    else $error("word accepted during clearing pass");

  a_write_in_wr: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(mem_rd))
    else $error("grid write without preceding read");

endmodule
